// ===== hdl/ttc_pkg.sv =====
`timescale 1ns / 1ps

package ttc_pkg;

  localparam int BUF_DEPTH    = 1024;
  localparam int MARKER_COUNT = 128;
  localparam int SLOT_W       = $clog2(BUF_DEPTH);
  localparam int COUNT_W      = $clog2(BUF_DEPTH + 1);
  localparam int TAG_W        = 8;
  localparam int TIME_W       = 64;
  localparam int ENTRY_W      = TAG_W + TIME_W;
  localparam int MASK_W       = 64;
  localparam int CFG_IDX_W    = 2;

  localparam logic [1:0] CMD_LOG   = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_CENTER = 2'd1;
  localparam logic [1:0] MODE_END    = 2'd2;

  localparam logic [2:0] STAT_DONE       = 3'd0;
  localparam logic [2:0] STAT_IGNORED    = 3'd1;
  localparam logic [2:0] STAT_BAD_FIRST  = 3'd2;
  localparam logic [2:0] STAT_BAD_REPEAT = 3'd3;
  localparam logic [2:0] STAT_BAD_MODE   = 3'd4;
  localparam logic [2:0] STAT_BAD_INDEX  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH   = 2'd3;

  typedef enum logic [1:0] {
    CAP_IDLE = 2'd0,
    CAP_WAIT = 2'd1,
    CAP_TRIG = 2'd2
  } cap_state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] marker_id;
    logic        is_exit;
    logic [31:0] time_high;
    logic [31:0] time_low;
    logic [1:0]  trigger_mode;
    logic [9:0]  read_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  capture_state;
    logic [10:0] stored_count;
    logic [9:0]  oldest_slot;
    logic [6:0]  read_marker;
    logic        read_exit;
    logic [63:0] read_time;
  } out_word_t;

  typedef struct packed {
    logic exec;
    logic capture_read;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_read;
  } dp_stat_t;

endpackage

// ===== hdl/ttc_ram.sv =====
`timescale 1ns / 1ps

module ttc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ttc_ctrl.sv =====
`timescale 1ns / 1ps

module ttc_ctrl import ttc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t ctl
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_OUT  = 3'b100
  } fsm_t;

  fsm_t state;
  fsm_t state_next;

  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    out_valid        = 1'b0;
    ctl.exec         = 1'b0;
    ctl.capture_read = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.exec   = 1'b1;
          state_next = stat.is_read ? ST_READ : ST_OUT;
        end
      end
      ST_READ: begin
        ctl.capture_read = 1'b1;
        state_next       = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/ttc_datapath.sv =====
`timescale 1ns / 1ps

module ttc_datapath import ttc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  in_word_t             in_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_data,
  input  ctl_cmd_t             ctl,
  output dp_stat_t             stat,
  output out_word_t            out_word
);

  logic [MASK_W-1:0] filter_low;
  logic [MASK_W-1:0] filter_high;
  logic [MASK_W-1:0] trig_low;
  logic [MASK_W-1:0] trig_high;

  cap_state_t         cap;
  cap_state_t         cap_next;
  logic [1:0]         sel_mode;
  logic [1:0]         sel_mode_next;
  logic [COUNT_W-1:0] after_cnt;
  logic [COUNT_W-1:0] after_cnt_next;
  logic [SLOT_W-1:0]  write_slot;
  logic [SLOT_W-1:0]  write_slot_next;
  logic [SLOT_W-1:0]  first_slot;
  logic [SLOT_W-1:0]  first_slot_next;
  logic [COUNT_W-1:0] held;
  logic [COUNT_W-1:0] held_next;
  logic               bad_seen;
  logic               bad_seen_next;
  logic               read_ok;

  logic [2:0]           status_v;
  logic                 marker_ok;
  logic [2*MASK_W-1:0]  filter_all;
  logic [2*MASK_W-1:0]  trig_all;
  logic                 filter_hit;
  logic                 trig_hit;
  logic [6:0]           marker;
  logic [COUNT_W-1:0]   idx_ext;
  logic                 read_hit;
  logic [COUNT_W-1:0]   cnt_inc;
  logic                 log_write;
  logic [ENTRY_W-1:0]   wdata;
  logic [ENTRY_W-1:0]   rdata;

  assign stat.is_read = (in_word.cmd == CMD_READ);
  assign marker       = in_word.marker_id[6:0];
  assign marker_ok    = in_word.marker_id < 32'(MARKER_COUNT);
  assign filter_all   = {filter_high, filter_low};
  assign trig_all     = {trig_high, trig_low};
  assign filter_hit   = filter_all[marker];
  assign trig_hit     = trig_all[marker];
  assign idx_ext      = COUNT_W'(in_word.read_index);
  assign read_hit     = (idx_ext < held) && (idx_ext < COUNT_W'(BUF_DEPTH));
  assign cnt_inc      = after_cnt + COUNT_W'(1);
  assign wdata        = {in_word.is_exit, marker, in_word.time_high, in_word.time_low};

  always_comb begin
    cap_next        = cap;
    sel_mode_next   = sel_mode;
    after_cnt_next  = after_cnt;
    write_slot_next = write_slot;
    first_slot_next = first_slot;
    held_next       = held;
    bad_seen_next   = bad_seen;
    status_v        = STAT_DONE;
    log_write       = 1'b0;
    case (in_word.cmd)
      CMD_LOG: begin
        if (cap == CAP_IDLE) begin
          status_v = STAT_IGNORED;
        end else if (!marker_ok) begin
          if (bad_seen) begin
            status_v = STAT_BAD_REPEAT;
          end else begin
            status_v      = STAT_BAD_FIRST;
            bad_seen_next = 1'b1;
          end
        end else if (!filter_hit) begin
          status_v = STAT_IGNORED;
        end else begin
          log_write = 1'b1;
          if (write_slot == SLOT_W'(BUF_DEPTH - 1)) begin
            write_slot_next = '0;
          end else begin
            write_slot_next = write_slot + SLOT_W'(1);
          end
          if (held < COUNT_W'(BUF_DEPTH)) begin
            held_next = held + COUNT_W'(1);
          end else begin
            first_slot_next = write_slot_next;
          end
          if (cap == CAP_TRIG || trig_hit) begin
            after_cnt_next = cnt_inc;
            cap_next       = CAP_TRIG;
            case (sel_mode)
              MODE_START: begin
                if (cnt_inc >= COUNT_W'(BUF_DEPTH)) begin
                  cap_next = CAP_IDLE;
                end
              end
              MODE_CENTER: begin
                if (cnt_inc >= COUNT_W'(BUF_DEPTH / 2)) begin
                  cap_next = CAP_IDLE;
                end
              end
              default: begin
                cap_next = CAP_IDLE;
              end
            endcase
          end
        end
      end
      CMD_START: begin
        if (in_word.trigger_mode inside {MODE_START, MODE_CENTER, MODE_END}) begin
          sel_mode_next   = in_word.trigger_mode;
          after_cnt_next  = '0;
          write_slot_next = '0;
          first_slot_next = '0;
          held_next       = '0;
          bad_seen_next   = 1'b0;
          cap_next        = CAP_WAIT;
        end else begin
          status_v = STAT_BAD_MODE;
        end
      end
      CMD_STOP: begin
        cap_next = CAP_IDLE;
      end
      default: begin
        if (!read_hit) begin
          status_v = STAT_BAD_INDEX;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_low  <= '1;
      filter_high <= '1;
      trig_low    <= '0;
      trig_high   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_LOW:  filter_low  <= cfg_data;
        REG_FILTER_HIGH: filter_high <= cfg_data;
        REG_TRIG_LOW:    trig_low    <= cfg_data;
        REG_TRIG_HIGH:   trig_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap        <= CAP_IDLE;
      sel_mode   <= MODE_START;
      after_cnt  <= '0;
      write_slot <= '0;
      first_slot <= '0;
      held       <= '0;
      bad_seen   <= 1'b0;
      read_ok    <= 1'b0;
    end else if (ctl.exec) begin
      cap        <= cap_next;
      sel_mode   <= sel_mode_next;
      after_cnt  <= after_cnt_next;
      write_slot <= write_slot_next;
      first_slot <= first_slot_next;
      held       <= held_next;
      bad_seen   <= bad_seen_next;
      read_ok    <= stat.is_read && read_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      out_word.status        <= status_v;
      out_word.capture_state <= 2'(cap_next);
      out_word.stored_count  <= 11'(held_next);
      out_word.oldest_slot   <= 10'(first_slot_next);
      out_word.read_marker   <= '0;
      out_word.read_exit     <= 1'b0;
      out_word.read_time     <= '0;
    end else if (ctl.capture_read && read_ok) begin
      out_word.read_exit   <= rdata[ENTRY_W-1];
      out_word.read_marker <= rdata[ENTRY_W-2:TIME_W];
      out_word.read_time   <= rdata[TIME_W-1:0];
    end
  end

  ttc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BUF_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ctl.exec && log_write),
    .waddr (write_slot),
    .wdata (wdata),
    .raddr (SLOT_W'(in_word.read_index)),
    .rdata (rdata)
  );

endmodule

// ===== hdl/triggered_trace_capture.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   in_word (in_word_t)
// out       output     out_valid / out_ready out_word (out_word_t)
// cfg       input      cfg_we                cfg_index, cfg_data
//
// A log, start or stop word goes from the idle state straight to the output state;
// a read word first passes through a read state for the registered entry RAM read.
// A new input word is taken only after the previous result word has been accepted.
// Reset is synchronous and active high; the entry RAM is not cleared.
// A stalled output holds its word and keeps in_ready low.

module triggered_trace_capture import ttc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_data
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  ttc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  ttc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_word  (out_word)
  );

endmodule
